@@ design/fca_pkg.sv @@
// Shared types and constants for the FAT32 cluster allocator.
`default_nettype none
package fca_pkg;

  // Default table depth in entries.
  localparam int TABLE_ENTRIES_DEF = 65536;

  // Fixed field widths.
  localparam int CMD_W     = 2;
  localparam int CLUSTER_W = 16;
  localparam int ENTRY_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INCONSISTENT = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_CLUSTER_TOTAL = 1'b0;
  localparam logic CFG_FREE_COUNT    = 1'b1;

  // Table constants.
  localparam logic [ENTRY_W-1:0]   END_OF_CHAIN      = 32'h0FFF_FFF8;
  localparam int                   RESERVED_ENTRIES  = 2;
  localparam logic [COUNT_W-1:0]   CLUSTER_TOTAL_RST = 16'd65534;

  // One command transaction.
  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [CLUSTER_W-1:0] cluster;
    logic [ENTRY_W-1:0]   entry_value;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  result_data;
    logic [COUNT_W-1:0]  free_left;
  } out_item_t;

endpackage
`default_nettype wire

@@ design/fat_cluster_allocator.sv @@
// Top level of the FAT32 cluster allocator: command sequencer around the table memory.
//
// The block keeps a FAT32 allocation table in one single-port memory and runs one
// command at a time; start is taken when busy is low and every command gives exactly
// one result, shown for one cycle with out_valid, which the receiver cannot stall.
// A write, a no-op, or an allocate with a zero free counter answers straight from idle; a
// read waits for the registered memory data. An allocate first sets up the scan, then
// visits table entries next-fit (the single memory port reads one entry a cycle), with
// a step at the wrap to entry 1 and at the end of the scan, then writes the link (when
// the previous cluster is nonzero) and marks the new cluster end-of-chain.
// After reset the memory is cleared one entry per cycle, with busy high; configuration
// writes are taken during that pass.
`default_nettype none
module fat_cluster_allocator import fca_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  output out_item_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [COUNT_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int SW = (AW + 1 > CLUSTER_W + 1) ? AW + 1 : CLUSTER_W + 1;
  localparam logic [SW-1:0] ENTRIES_W  = SW'(TABLE_ENTRIES);
  localparam logic [SW-1:0] ONE_W      = SW'(1);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(TABLE_ENTRIES - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [COUNT_W-1:0] cluster_total_r, cluster_total_nxt;
  logic [COUNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  // Per-command working registers.
  logic [SW-1:0]      clus_r, clus_nxt;
  logic               clus_ok_r, clus_ok_nxt;
  logic [SW-1:0]      span_r, span_nxt;
  logic [SW-1:0]      wrap_end_r, wrap_end_nxt;
  logic [SW-1:0]      ptr_r, ptr_nxt;
  logic               wrapped_r, wrapped_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      pend_addr_r, pend_addr_nxt;
  logic [AW-1:0]      found_r, found_nxt;

  // Memory port.
  logic               mem_en;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  // Decoded input fields.
  logic [SW-1:0]      in_clus;
  logic               in_clus_ok;
  logic [SW-1:0]      in_span_raw;
  logic [SW-1:0]      in_span;
  logic               hit;

  fca_table #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Index range and span of the table in use, capped at the memory depth.
  assign in_clus     = SW'(in_data.cluster);
  assign in_clus_ok  = in_clus < ENTRIES_W;
  assign in_span_raw = SW'(cluster_total_r) + SW'(RESERVED_ENTRIES);
  assign in_span     = (in_span_raw > ENTRIES_W) ? ENTRIES_W : in_span_raw;

  // A free entry was read in the previous scan cycle.
  assign hit = pend_r && (mem_rdata == '0);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer and configuration logic.
  always_comb begin
    state_nxt         = state_r;
    clr_nxt           = clr_r;
    cluster_total_nxt = cluster_total_r;
    free_cnt_nxt      = free_cnt_r;
    out_valid_nxt     = 1'b0;
    out_nxt           = out_r;
    clus_nxt          = clus_r;
    clus_ok_nxt       = clus_ok_r;
    span_nxt          = span_r;
    wrap_end_nxt      = wrap_end_r;
    ptr_nxt           = ptr_r;
    wrapped_nxt       = wrapped_r;
    pend_nxt          = pend_r;
    pend_addr_nxt     = pend_addr_r;
    found_nxt         = found_r;
    mem_en            = 1'b0;
    mem_we            = 1'b0;
    mem_addr          = '0;
    mem_wdata         = '0;

    // The user must make configuration writes only while no command is in flight; the block itself does not enforce it.
    if (cfg_we) begin
      if (cfg_index == CFG_CLUSTER_TOTAL) begin
        cluster_total_nxt = cfg_wdata;
      end else begin
        free_cnt_nxt = cfg_wdata;
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          clus_nxt    = in_clus;
          clus_ok_nxt = in_clus_ok;
          out_nxt.status      = ST_OK;
          out_nxt.result_data = '0;
          out_nxt.free_left   = free_cnt_r;
          unique case (in_data.cmd)
            CMD_READ: begin
              mem_en    = in_clus_ok;
              mem_addr  = in_clus[AW-1:0];
              state_nxt = S_READ;
            end
            CMD_WRITE: begin
              mem_en        = in_clus_ok;
              mem_we        = 1'b1;
              mem_addr      = in_clus[AW-1:0];
              mem_wdata     = in_data.entry_value;
              out_valid_nxt = 1'b1;
            end
            CMD_ALLOC: begin
              if (free_cnt_r == '0) begin
                out_nxt.status = ST_NO_SPACE;
                out_valid_nxt  = 1'b1;
              end else begin
                span_nxt     = in_span;
                wrap_end_nxt = (in_clus < in_span) ? in_clus : in_span;
                ptr_nxt      = (in_clus == '0) ? ONE_W : in_clus;
                wrapped_nxt  = 1'b0;
                pend_nxt     = 1'b0;
                state_nxt    = S_SCAN;
              end
            end
            CMD_NOP: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        out_nxt.result_data = clus_ok_r ? mem_rdata : '0;
        out_valid_nxt       = 1'b1;
        state_nxt           = S_IDLE;
      end

      // Next-fit scan: issue one read a cycle, check the one issued before.
      S_SCAN: begin
        if (hit) begin
          found_nxt = pend_addr_r;
          pend_nxt  = 1'b0;
          state_nxt = (clus_r != '0) ? S_LINK : S_MARK;
        end else if (!wrapped_r) begin
          if (ptr_r < span_r) begin
            mem_en        = 1'b1;
            mem_addr      = ptr_r[AW-1:0];
            pend_nxt      = 1'b1;
            pend_addr_nxt = ptr_r[AW-1:0];
            ptr_nxt       = ptr_r + ONE_W;
          end else begin
            wrapped_nxt = 1'b1;
            ptr_nxt     = ONE_W;
            pend_nxt    = 1'b0;
          end
        end else begin
          if (ptr_r < wrap_end_r) begin
            mem_en        = 1'b1;
            mem_addr      = ptr_r[AW-1:0];
            pend_nxt      = 1'b1;
            pend_addr_nxt = ptr_r[AW-1:0];
            ptr_nxt       = ptr_r + ONE_W;
          end else begin
            // Nothing free although the counter says otherwise.
            pend_nxt       = 1'b0;
            out_nxt.status = ST_INCONSISTENT;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end

      // Link the previous cluster of the chain to the new one.
      S_LINK: begin
        mem_en    = clus_ok_r;
        mem_we    = 1'b1;
        mem_addr  = clus_r[AW-1:0];
        mem_wdata = ENTRY_W'(found_r);
        state_nxt = S_MARK;
      end

      // Mark the new cluster as end of chain and take it off the counter.
      S_MARK: begin
        mem_en                = 1'b1;
        mem_we                = 1'b1;
        mem_addr              = found_r;
        mem_wdata             = END_OF_CHAIN;
        free_cnt_nxt          = free_cnt_r - COUNT_W'(1);
        out_nxt.status        = ST_OK;
        out_nxt.result_data   = ENTRY_W'(found_r);
        out_nxt.free_left     = free_cnt_r - COUNT_W'(1);
        out_valid_nxt         = 1'b1;
        state_nxt             = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_r           <= '0;
      cluster_total_r <= CLUSTER_TOTAL_RST;
      free_cnt_r      <= '0;
      out_valid_r     <= 1'b0;
      pend_r          <= 1'b0;
      wrapped_r       <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      clr_r           <= clr_nxt;
      cluster_total_r <= cluster_total_nxt;
      free_cnt_r      <= free_cnt_nxt;
      out_valid_r     <= out_valid_nxt;
      pend_r          <= pend_nxt;
      wrapped_r       <= wrapped_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    clus_r      <= clus_nxt;
    clus_ok_r   <= clus_ok_nxt;
    span_r      <= span_nxt;
    wrap_end_r  <= wrap_end_nxt;
    ptr_r       <= ptr_nxt;
    pend_addr_r <= pend_addr_nxt;
    found_r     <= found_nxt;
  end

endmodule
`default_nettype wire

@@ design/fca_table.sv @@
// Single-port allocation table memory with registered read data.
`default_nettype none
module fca_table import fca_pkg::*; #(
  parameter int ENTRIES = TABLE_ENTRIES_DEF,
  localparam int AW = $clog2(ENTRIES)
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic               we,
  input  wire logic [AW-1:0]      addr,
  input  wire logic [ENTRY_W-1:0] wdata,
  output logic      [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem_r [ENTRIES];
  logic [ENTRY_W-1:0] rdata_r;

  // One access per cycle: either a write or a read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire
